[rtl/spnfa_pkg.sv]
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Shared widths, register indexes, status and operation codes, and the
// structs that pass between the controller, the flag memory and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package spnfa_pkg;

  localparam int HwSlots      = 32;
  localparam int DefaultSlots = 32;

  localparam int SizeW   = 16;
  localparam int CountW  = 6;
  localparam int SlotW   = 5;
  localparam int StatusW = 2;
  localparam int CfgIdxW = 1;

  localparam logic [SizeW-1:0]  SlotSizeReset  = 16'd256;
  localparam logic [CountW-1:0] SlotCountReset = 6'd32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSlotSize  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSlotCount = 1'b1;

  // Operation codes
  localparam logic OpAcquire = 1'b0;
  localparam logic OpRelease = 1'b1;

  // Status codes
  localparam logic [StatusW-1:0] StOk        = 2'd0;
  localparam logic [StatusW-1:0] StExhausted = 2'd1;
  localparam logic [StatusW-1:0] StTooLarge  = 2'd2;
  localparam logic [StatusW-1:0] StBadIndex  = 2'd3;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [SlotW-1:0] addr;
    logic             wdata;
  } ram_req_t;

  typedef struct packed {
    logic               granted;
    logic [SlotW-1:0]   slot;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

`default_nettype wire

[rtl/slot_pool_next_fit_allocator.sv]
// ----------------------------------------------------------------------------
// Slot pool next-fit allocator
// Fixed-size slot pool with per-slot busy flags and a rotating grant pointer.
// ----------------------------------------------------------------------------
// Each input item is an acquire or a release and yields exactly one result
// item. An acquire whose request_size exceeds slot_size fails with status
// "too large" at once. Otherwise the busy flags are checked one slot per
// cycle, starting after the slot granted last and wrapping at the slot count
// in use (slot_count clamped to 1..min(Slots, 32)); the first free slot is
// marked busy and granted. If all are busy the result is "exhausted" and the
// pointer stays. A release frees an in-range slot (freeing a free slot is
// harmless) or reports "bad index". The flags live in a one-port memory with
// registered read data, so an acquire has an accept step, one flag read per
// slot inspected (at most the slot count in use, 32 by default), then a step
// handing the result to the output register; releases and oversized requests
// have only the accept and hand-over steps. One item is processed at a time;
// the output register lets the next item be accepted while a result waits.
// After reset the memory is cleared in a sweep over all min(Slots, 32)
// entries, during which s_axis_tready_o stays low; configuration writes are
// always accepted and should only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_pool_next_fit_allocator #(
  parameter int Slots = spnfa_pkg::DefaultSlots
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Input items
  input  wire                              s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire  [23:0]                      s_axis_tdata_i,  // [15:0] request_size,
                                                            // [20:16] slot_index
  input  wire                              s_axis_tuser_i,  // [0] operation
  // Result items
  output logic                             m_axis_tvalid_o,
  input  wire                              m_axis_tready_i,
  output logic [7:0]                       m_axis_tdata_o,  // [4:0] granted_slot,
                                                            // [6:5] status
  output logic                             m_axis_tuser_o,  // [0] granted
  // Configuration writes
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [spnfa_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [spnfa_pkg::SizeW-1:0]      cfg_data_i
);
  import spnfa_pkg::*;

  localparam int Depth = (Slots < HwSlots) ? Slots : HwSlots;

  logic [SizeW-1:0]  slot_size_q;
  logic [CountW-1:0] slot_count_q;

  ram_req_t ram_req;
  logic     ram_rd;
  logic     res_valid;
  logic     res_ready;
  result_t  res;

  logic     out_valid_q;
  result_t  out_q;

  // Configuration registers; the port never stalls
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_size_q  <= SlotSizeReset;
      slot_count_q <= SlotCountReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSlotSize:  slot_size_q  <= cfg_data_i;
        CfgSlotCount: slot_count_q <= cfg_data_i[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  spnfa_flag_ram #(
    .Depth(Depth)
  ) u_flag_ram (
    .clk_i    (clk_i),
    .req_i    (ram_req),
    .rd_data_o(ram_rd)
  );

  spnfa_ctrl #(
    .Depth(Depth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .op_i        (s_axis_tuser_i),
    .req_size_i  (s_axis_tdata_i[15:0]),
    .idx_i       (s_axis_tdata_i[20:16]),
    .slot_size_i (slot_size_q),
    .slot_count_i(slot_count_q),
    .ram_req_o   (ram_req),
    .ram_rd_i    (ram_rd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.granted;
  assign m_axis_tdata_o  = {1'b0, out_q.status, out_q.slot};

endmodule

`default_nettype wire

[rtl/spnfa_flag_ram.sv]
// ----------------------------------------------------------------------------
// Busy flag memory
// One bit per slot, one access per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module spnfa_flag_ram #(
  parameter int Depth = spnfa_pkg::HwSlots
) (
  input  wire                       clk_i,
  input  wire spnfa_pkg::ram_req_t  req_i,
  output logic                      rd_data_o
);
  import spnfa_pkg::*;

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic             mem [Depth];
  logic [AddrW-1:0] addr;

  assign addr = req_i.addr[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_o <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[rtl/spnfa_ctrl.sv]
// ----------------------------------------------------------------------------
// Slot pool controller
// Clears the flag memory after reset, then runs acquire searches and
// releases against it, one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module spnfa_ctrl #(
  parameter int Depth = spnfa_pkg::HwSlots
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              op_i,
  input  wire  [spnfa_pkg::SizeW-1:0]      req_size_i,
  input  wire  [spnfa_pkg::SlotW-1:0]      idx_i,
  input  wire  [spnfa_pkg::SizeW-1:0]      slot_size_i,
  input  wire  [spnfa_pkg::CountW-1:0]     slot_count_i,
  output spnfa_pkg::ram_req_t              ram_req_o,
  input  wire                              ram_rd_i,
  output logic                             res_valid_o,
  input  wire                              res_ready_i,
  output spnfa_pkg::result_t               res_o
);
  import spnfa_pkg::*;

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [1:0] SClear  = 2'd0;
  localparam logic [1:0] SIdle   = 2'd1;
  localparam logic [1:0] SSearch = 2'd2;
  localparam logic [1:0] SDone   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [SlotW-1:0]  pos_q, pos_d;
  logic [SlotW-1:0]  cnt_q, cnt_d;
  logic [SlotW-1:0]  last_q, last_d;
  result_t           res_q, res_d;

  logic [CountW-1:0] n_act;
  logic [CountW-1:0] last_slot;
  logic [SlotW-1:0]  start_pos;
  logic [SlotW-1:0]  next_pos;

  // Slots in use: count clamped to 1..Depth
  always_comb begin
    n_act = slot_count_i;
    if (n_act == '0) begin
      n_act = CountW'(1);
    end
    if (n_act > CountW'(Depth)) begin
      n_act = CountW'(Depth);
    end
  end

  assign last_slot = n_act - CountW'(1);
  assign start_pos = ({1'b0, last_q} >= last_slot) ? '0 : last_q + SlotW'(1);
  assign next_pos  = ({1'b0, pos_q} >= last_slot) ? '0 : pos_q + SlotW'(1);

  assign in_ready_o  = (state_q == SIdle);
  assign res_valid_o = (state_q == SDone);
  assign res_o       = res_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    res_d     = res_q;
    ram_req_o = '0;

    case (state_q)
      SClear: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = SlotW'(clr_q);
        ram_req_o.wdata = 1'b0;
        clr_d           = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = SIdle;
        end
      end

      SIdle: begin
        if (in_valid_i) begin
          res_d = '0;
          if (op_i == OpRelease) begin
            if ({1'b0, idx_i} >= n_act) begin
              res_d.status = StBadIndex;
            end else begin
              ram_req_o.we    = 1'b1;
              ram_req_o.addr  = idx_i;
              ram_req_o.wdata = 1'b0;
              res_d.status    = StOk;
            end
            state_d = SDone;
          end else if (req_size_i > slot_size_i) begin
            res_d.status = StTooLarge;
            state_d      = SDone;
          end else begin
            // Issue the first flag read; its data shows up next cycle
            ram_req_o.re   = 1'b1;
            ram_req_o.addr = start_pos;
            pos_d          = start_pos;
            cnt_d          = '0;
            state_d        = SSearch;
          end
        end
      end

      SSearch: begin
        if (!ram_rd_i) begin
          // Free slot: mark busy and grant
          ram_req_o.we    = 1'b1;
          ram_req_o.addr  = pos_q;
          ram_req_o.wdata = 1'b1;
          last_d          = pos_q;
          res_d.granted   = 1'b1;
          res_d.slot      = pos_q;
          res_d.status    = StOk;
          state_d         = SDone;
        end else if ({1'b0, cnt_q} == last_slot) begin
          res_d.status = StExhausted;
          state_d      = SDone;
        end else begin
          ram_req_o.re   = 1'b1;
          ram_req_o.addr = next_pos;
          pos_d          = next_pos;
          cnt_d          = cnt_q + SlotW'(1);
        end
      end

      SDone: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q   <= '0;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

endmodule

`default_nettype wire
